// File: sv/mtsg_pkg.sv
// Shared types and constants for the multimode test signal generator.
`timescale 1ns / 1ps

package mtsg_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int SAMPLE_W = 24;
    localparam int MAG_W = 17;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_TONE = 2'd2,
        KIND_TWO  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic signed [SAMPLE_W-1:0]   in_i;
        logic signed [SAMPLE_W-1:0]   in_q;
    } sample_t;

    typedef struct packed {
        logic [MAG_W-1:0] one;
        logic [MAG_W-1:0] two;
    } mag_t;

endpackage

// File: sv/mtsg_queue.sv
// Short request queue between the front and back sections.
`timescale 1ns / 1ps

module mtsg_queue #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             wr_ready,
    output logic             rd_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = mtsg_pkg::QUEUE_PTR_W;
    localparam int CW = mtsg_pkg::QUEUE_CNT_W;

    logic [WIDTH-1:0] mem_reg [mtsg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign wr_ready = (count_reg != CW'(mtsg_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/mtsg_front.sv
// Front section: configuration registers, phase accumulators and request classification.
`timescale 1ns / 1ps

module mtsg_front #(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [3:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [23:0]       in_i,
    input  logic signed [23:0]       in_q,
    input  logic                     q_ready,
    output logic                     q_push,
    output mtsg_pkg::sample_t        q_entry,
    output logic [TABLE_BITS-1:0]    q_idx_one,
    output logic [TABLE_BITS-1:0]    q_idx_two,
    output mtsg_pkg::mag_t           mag
);

    localparam logic [3:0] REG_RUN      = 4'd0;
    localparam logic [3:0] REG_MODE     = 4'd1;
    localparam logic [3:0] REG_STEP_ONE = 4'd2;
    localparam logic [3:0] REG_STEP_TWO = 4'd3;
    localparam logic [3:0] REG_CHIRP    = 4'd4;
    localparam logic [3:0] REG_MAG_ONE  = 4'd5;
    localparam logic [3:0] REG_MAG_TWO  = 4'd6;

    localparam logic [2:0] MODE_TONE  = 3'd0;
    localparam logic [2:0] MODE_TWO   = 3'd1;
    localparam logic [2:0] MODE_SWEEP = 3'd3;

    localparam logic [31:0] RST_STEP_ONE = 32'd89478485;
    localparam logic [16:0] RST_MAG_ONE  = 17'd65536;
    localparam logic [16:0] RST_MAG_TWO  = 17'd32768;

    logic                  run_reg, run_next;
    logic [2:0]            mode_reg, mode_next;
    logic [31:0]           step_one_reg, step_one_next;
    logic [31:0]           step_two_reg, step_two_next;
    logic [31:0]           chirp_reg, chirp_next;
    logic [16:0]           mag_one_reg, mag_one_next;
    logic [16:0]           mag_two_reg, mag_two_next;
    logic [PHASE_BITS-1:0] phase_one_reg, phase_one_next;
    logic [PHASE_BITS-1:0] phase_two_reg, phase_two_next;
    logic [47:0]           sweep_reg, sweep_next;
    logic [47:0]           sweep_sum;
    logic                  listed;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_ready;
    assign q_push    = in_valid && q_ready;
    assign listed    = (cfg_index <= REG_MAG_TWO);
    assign sweep_sum = sweep_reg + {{16{chirp_reg[31]}}, chirp_reg};

    assign q_idx_one = phase_one_reg[PHASE_BITS-1 -: TABLE_BITS];
    assign q_idx_two = phase_two_reg[PHASE_BITS-1 -: TABLE_BITS];
    assign mag.one   = mag_one_reg;
    assign mag.two   = mag_two_reg;

    always_comb
    begin
        q_entry.in_i = in_i;
        q_entry.in_q = in_q;
        if (!run_reg)
        begin
            q_entry.kind = mtsg_pkg::KIND_PASS;
        end
        else if (mode_reg inside {MODE_TONE, MODE_SWEEP})
        begin
            q_entry.kind = mtsg_pkg::KIND_TONE;
        end
        else if (mode_reg == MODE_TWO)
        begin
            q_entry.kind = mtsg_pkg::KIND_TWO;
        end
        else
        begin
            q_entry.kind = mtsg_pkg::KIND_ZERO;
        end
    end

    always_comb
    begin
        run_next       = run_reg;
        mode_next      = mode_reg;
        step_one_next  = step_one_reg;
        step_two_next  = step_two_reg;
        chirp_next     = chirp_reg;
        mag_one_next   = mag_one_reg;
        mag_two_next   = mag_two_reg;
        phase_one_next = phase_one_reg;
        phase_two_next = phase_two_reg;
        sweep_next     = sweep_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RUN:      run_next      = cfg_data[0];
                REG_MODE:     mode_next     = cfg_data[2:0];
                REG_STEP_ONE: step_one_next = cfg_data;
                REG_STEP_TWO: step_two_next = cfg_data;
                REG_CHIRP:    chirp_next    = cfg_data;
                REG_MAG_ONE:  mag_one_next  = cfg_data[16:0];
                REG_MAG_TWO:  mag_two_next  = cfg_data[16:0];
                default:      ;
            endcase
        end
        if (cfg_valid && listed)
        begin
            phase_one_next = '0;
            phase_two_next = '0;
            sweep_next     = {step_one_next, 16'h0000};
        end
        else if (q_push && run_reg)
        begin
            case (mode_reg)
                MODE_TONE:
                begin
                    phase_one_next = phase_one_reg + step_one_reg[PHASE_BITS-1:0];
                end
                MODE_TWO:
                begin
                    phase_one_next = phase_one_reg + step_one_reg[PHASE_BITS-1:0];
                    phase_two_next = phase_two_reg + step_two_reg[PHASE_BITS-1:0];
                end
                MODE_SWEEP:
                begin
                    phase_one_next = phase_one_reg + sweep_reg[16 +: PHASE_BITS];
                    if ($signed(sweep_sum) > $signed({step_two_reg, 16'h0000}))
                    begin
                        sweep_next = {step_one_reg, 16'h0000};
                    end
                    else
                    begin
                        sweep_next = sweep_sum;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            mode_reg      <= '0;
            step_one_reg  <= RST_STEP_ONE;
            step_two_reg  <= '0;
            chirp_reg     <= '0;
            mag_one_reg   <= RST_MAG_ONE;
            mag_two_reg   <= RST_MAG_TWO;
            phase_one_reg <= '0;
            phase_two_reg <= '0;
            sweep_reg     <= {RST_STEP_ONE, 16'h0000};
        end
        else
        begin
            run_reg       <= run_next;
            mode_reg      <= mode_next;
            step_one_reg  <= step_one_next;
            step_two_reg  <= step_two_next;
            chirp_reg     <= chirp_next;
            mag_one_reg   <= mag_one_next;
            mag_two_reg   <= mag_two_next;
            phase_one_reg <= phase_one_next;
            phase_two_reg <= phase_two_next;
            sweep_reg     <= sweep_next;
        end
    end

endmodule

// File: sv/mtsg_sine_rom.sv
// Dual read port sine ROM with registered outputs.
`timescale 1ns / 1ps

module mtsg_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [TABLE_BITS-1:0] addr_a,
    input  logic [TABLE_BITS-1:0] addr_b,
    output logic signed [23:0]    data_a,
    output logic signed [23:0]    data_b
);

    localparam int  TSIZE   = 1 << TABLE_BITS;
    localparam int  QUARTER = TSIZE / 4;
    localparam int  HALF    = TSIZE / 2;
    localparam real PI      = 3.14159265358979323846;
    localparam real STEP_RAD = 2.0 * PI / real'(TSIZE);

    typedef logic signed [23:0] rom_t [TSIZE];

    function automatic rom_t build_rom();
        rom_t rom;
        real  x;
        int   v;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = 8388607.0 * $sin(STEP_RAD * real'(k)) + 0.5;
            v = $rtoi(x);
            if (v > 8388607)
            begin
                v = 8388607;
            end
            rom[k] = 24'(v);
        end
        for (int k = QUARTER + 1; k < HALF; k++)
        begin
            rom[k] = rom[HALF - k];
        end
        for (int k = HALF; k < TSIZE; k++)
        begin
            rom[k] = -rom[k - HALF];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= SINE_ROM[addr_a];
            data_b <= SINE_ROM[addr_b];
        end
    end

endmodule

// File: sv/mtsg_back.sv
// Back section: table lookup, amplitude multiply, sum, shift, saturate, output register.
`timescale 1ns / 1ps

module mtsg_back #(
    parameter int TABLE_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  mtsg_pkg::sample_t     q_entry,
    input  logic [TABLE_BITS-1:0] q_idx_one,
    input  logic [TABLE_BITS-1:0] q_idx_two,
    input  mtsg_pkg::mag_t        mag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [23:0]    out_i,
    output logic signed [23:0]    out_q
);

    localparam logic [TABLE_BITS-1:0] QUARTER = TABLE_BITS'(1 << (TABLE_BITS - 2));

    function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
        logic signed [43:0] s;
        s = v >>> 16;
        if (s > 44'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        else if (s < -44'sd8388608)
        begin
            return 24'sh800000;
        end
        return s[23:0];
    endfunction

    logic                     en;
    logic signed [23:0]       sin_one, cos_one, sin_two, cos_two;
    logic signed [17:0]       amp_one, amp_two;
    logic signed [41:0]       prod_i1, prod_q1, prod_i2, prod_q2;
    logic signed [43:0]       sum_i, sum_q;

    logic                     s1_valid_reg, s2_valid_reg, out_valid_reg;
    mtsg_pkg::sample_t        s1_info_reg, s2_info_reg;
    logic signed [41:0]       pi1_reg, pq1_reg, pi2_reg, pq2_reg;
    logic signed [23:0]       out_i_reg, out_q_reg, res_i, res_q;

    assign en        = !out_valid_reg || out_ready;
    assign q_pop     = q_valid && en;
    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

    mtsg_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom_one (
        .clk    (clk),
        .en     (en),
        .addr_a (q_idx_one),
        .addr_b (TABLE_BITS'(q_idx_one + QUARTER)),
        .data_a (sin_one),
        .data_b (cos_one)
    );

    mtsg_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom_two (
        .clk    (clk),
        .en     (en),
        .addr_a (q_idx_two),
        .addr_b (TABLE_BITS'(q_idx_two + QUARTER)),
        .data_a (sin_two),
        .data_b (cos_two)
    );

    assign amp_one = $signed({1'b0, mag.one});
    assign amp_two = (s1_info_reg.kind == mtsg_pkg::KIND_TWO) ? $signed({1'b0, mag.two}) : '0;
    assign prod_i1 = amp_one * cos_one;
    assign prod_q1 = amp_one * sin_one;
    assign prod_i2 = amp_two * cos_two;
    assign prod_q2 = amp_two * sin_two;

    assign sum_i = 44'(pi1_reg) + 44'(pi2_reg);
    assign sum_q = -44'(pq1_reg) - 44'(pq2_reg);

    always_comb
    begin
        case (s2_info_reg.kind)
            mtsg_pkg::KIND_PASS:
            begin
                res_i = s2_info_reg.in_i;
                res_q = s2_info_reg.in_q;
            end
            mtsg_pkg::KIND_TONE, mtsg_pkg::KIND_TWO:
            begin
                res_i = sat24(sum_i);
                res_q = sat24(sum_q);
            end
            default:
            begin
                res_i = '0;
                res_q = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_info_reg <= q_entry;
            s2_info_reg <= s1_info_reg;
            pi1_reg     <= prod_i1;
            pq1_reg     <= prod_q1;
            pi2_reg     <= prod_i2;
            pq2_reg     <= prod_q2;
            out_i_reg   <= res_i;
            out_q_reg   <= res_q;
        end
    end

endmodule

// File: sv/multimode_test_signal_generator_unit.sv
// Throughput: one request per cycle while out_ready does not stall the back section,
// set by the phase accumulator update in the front section; the back section is a
// three-stage ROM/multiply/saturate pipe.
// Reset (rst_n low, asynchronous): registers take their reset values, phases clear,
// sweep step reloads, queue and pipeline empty; the sine ROM is constant.
`timescale 1ns / 1ps

module multimode_test_signal_generator_unit #(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] in_i,
    input  logic signed [23:0] in_q,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] out_i,
    output logic signed [23:0] out_q
);

    localparam int QW = $bits(mtsg_pkg::sample_t) + 2 * TABLE_BITS;

    logic                  q_push, q_ready, q_valid, q_pop;
    mtsg_pkg::sample_t     f_entry, b_entry;
    logic [TABLE_BITS-1:0] f_idx_one, f_idx_two, b_idx_one, b_idx_two;
    mtsg_pkg::mag_t        mag;
    logic [QW-1:0]         q_rd_data;

    mtsg_front #(.PHASE_BITS(PHASE_BITS), .TABLE_BITS(TABLE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_i      (in_i),
        .in_q      (in_q),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_entry   (f_entry),
        .q_idx_one (f_idx_one),
        .q_idx_two (f_idx_two),
        .mag       (mag)
    );

    mtsg_queue #(.WIDTH(QW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  ({f_entry, f_idx_one, f_idx_two}),
        .wr_ready (q_ready),
        .rd_valid (q_valid),
        .pop      (q_pop),
        .rd_data  (q_rd_data)
    );

    assign {b_entry, b_idx_one, b_idx_two} = q_rd_data;

    mtsg_back #(.TABLE_BITS(TABLE_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (b_entry),
        .q_idx_one (b_idx_one),
        .q_idx_two (b_idx_two),
        .mag       (mag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_i     (out_i),
        .out_q     (out_q)
    );

`ifndef SYNTHESIS
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_pop |=> q_valid)
        else $error("queue dropped a pending request");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> in_ready)
        else $error("input stalled while queue empty");

    a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid || out_ready))
        else $error("queue popped while back section stalled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |=> q_valid)
        else $error("pushed request not visible at queue head");
`endif

endmodule
